// ===== rtl/core/sha256_message_hasher_core_macros.svh =====
// Assertion macros used by the SHA-256 hasher checker.
`ifndef SHA256_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASHER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SHM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SHM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/shm_pkg.sv =====
// Types, state encoding and constants of the SHA-256 message hasher.
`timescale 1ns / 1ps
package shm_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] vars_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FOLD,
		ST_EMIT
	} st_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	localparam vars_t INIT_H = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== rtl/core/shm_round.sv =====
// One SHA-256 round with the matching message schedule step.
`timescale 1ns / 1ps
module shm_round (
	input  shm_pkg::vars_t vars,
	input  shm_pkg::word_t k,
	input  shm_pkg::word_t w0,
	input  shm_pkg::word_t w1,
	input  shm_pkg::word_t w9,
	input  shm_pkg::word_t w14,
	output shm_pkg::vars_t vars_next,
	output shm_pkg::word_t w_new
);

	function automatic shm_pkg::word_t rotr(input shm_pkg::word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	shm_pkg::word_t big0;
	shm_pkg::word_t big1;
	shm_pkg::word_t choose;
	shm_pkg::word_t major;
	shm_pkg::word_t t1;
	shm_pkg::word_t t2;
	shm_pkg::word_t sig0;
	shm_pkg::word_t sig1;

	always_comb begin
		big1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
		choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		big0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
		major = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1 = vars[7] + big1 + choose + k + w0;
		t2 = big0 + major;
		vars_next[7] = vars[6];
		vars_next[6] = vars[5];
		vars_next[5] = vars[4];
		vars_next[4] = vars[3] + t1;
		vars_next[3] = vars[2];
		vars_next[2] = vars[1];
		vars_next[1] = vars[0];
		vars_next[0] = t1 + t2;
		sig0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		sig1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		w_new = sig1 + w9 + sig0 + w0;
	end

endmodule

// ===== rtl/core/sha256_message_hasher_core.sv =====
// Top level of the SHA-256 message hasher: byte intake, padding and round sequencer.
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | s_axis_tvalid, s_axis_tready | tdata: data_byte; tuser: byte_present;
//           |           |                              | tlast: message_end
//  m_axis   | out       | m_axis_tvalid, m_axis_tready | tdata: digest_part_0..3
// A byte request is accepted in the idle state; the byte that fills a block adds 64 rounds
// on the shared round unit plus a fold step. An end request adds the pad bytes and the
// rounds and fold of each padded block (one or two blocks), then the digest load.
// tready is low during padding, rounds, fold and digest load; the digest load waits
// while the previous digest is still held. Reset restores the initial hash values.
`timescale 1ns / 1ps
module sha256_message_hasher_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tuser,   // [0] byte_present
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [255:0] m_axis_tdata    // [63:0] digest_part_0, [127:64] digest_part_1,
	                                     // [191:128] digest_part_2, [255:192] digest_part_3
);

	shm_pkg::st_t   state_q;
	shm_pkg::st_t   state_d;
	logic [5:0]     fill_q;
	logic [63:0]    bits_q;
	logic [511:0]   blk_q;
	shm_pkg::vars_t chain_q;
	shm_pkg::vars_t v_q;
	shm_pkg::vars_t v_round;
	shm_pkg::vars_t fold_sum;
	shm_pkg::word_t w_new;
	logic [5:0]     rnd_q;
	logic           pad_q;
	logic           first_q;
	logic           lenok_q;
	logic           final_q;
	logic [255:0]   dig_q;
	logic           out_valid_q;
	logic           accept;
	logic           shift_en;
	logic [7:0]     shift_byte;
	logic           emit_load;
	logic [5:0]     fill_after;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign fill_after = fill_q + {5'd0, s_axis_tuser};

	shm_round u_round (
		.vars      (v_q),
		.k         (shm_pkg::ROUND_K[rnd_q]),
		.w0        (blk_q[511:480]),
		.w1        (blk_q[479:448]),
		.w9        (blk_q[223:192]),
		.w14       (blk_q[63:32]),
		.vars_next (v_round),
		.w_new     (w_new)
	);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fold_sum[i] = chain_q[i] + v_q[i];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shm_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser && fill_q == shm_pkg::LAST_POS) begin
						state_d = shm_pkg::ST_COMP;
					end else if (s_axis_tlast) begin
						state_d = shm_pkg::ST_PAD;
					end
				end
			end
			shm_pkg::ST_PAD: begin
				if (fill_q == shm_pkg::LAST_POS) begin
					state_d = shm_pkg::ST_COMP;
				end
			end
			shm_pkg::ST_COMP: begin
				if (rnd_q == shm_pkg::LAST_ROUND) begin
					state_d = shm_pkg::ST_FOLD;
				end
			end
			shm_pkg::ST_FOLD: begin
				if (final_q) begin
					state_d = shm_pkg::ST_EMIT;
				end else if (pad_q) begin
					state_d = shm_pkg::ST_PAD;
				end else begin
					state_d = shm_pkg::ST_IDLE;
				end
			end
			shm_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = shm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		shift_en = 1'b0;
		shift_byte = s_axis_tdata;
		emit_load = 1'b0;
		case (state_q)
			shm_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				shift_en = s_axis_tvalid && s_axis_tuser;
			end
			shm_pkg::ST_PAD: begin
				shift_en = 1'b1;
				if (first_q) begin
					shift_byte = shm_pkg::PAD_BYTE;
				end else if (lenok_q && fill_q >= shm_pkg::LEN_POS) begin
					shift_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
				end else begin
					shift_byte = 8'd0;
				end
			end
			shm_pkg::ST_EMIT: begin
				emit_load = !out_valid_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shm_pkg::ST_IDLE;
			fill_q <= 6'd0;
			bits_q <= 64'd0;
			chain_q <= shm_pkg::INIT_H;
			v_q <= shm_pkg::INIT_H;
			rnd_q <= 6'd0;
			pad_q <= 1'b0;
			first_q <= 1'b0;
			lenok_q <= 1'b0;
			final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (accept && s_axis_tuser) begin
				bits_q <= bits_q + shm_pkg::BYTE_BITS;
			end
			if (accept && s_axis_tlast) begin
				pad_q <= 1'b1;
				first_q <= 1'b1;
				lenok_q <= fill_after < shm_pkg::LEN_POS;
			end
			if (state_q == shm_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (fill_q == shm_pkg::LAST_POS) begin
					final_q <= lenok_q;
					lenok_q <= 1'b1;
				end
			end
			if (state_q == shm_pkg::ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
				v_q <= v_round;
			end
			if (state_q == shm_pkg::ST_FOLD) begin
				chain_q <= fold_sum;
				v_q <= fold_sum;
			end
			if (emit_load) begin
				chain_q <= shm_pkg::INIT_H;
				v_q <= shm_pkg::INIT_H;
				bits_q <= 64'd0;
				fill_q <= 6'd0;
				pad_q <= 1'b0;
				final_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (state_q == shm_pkg::ST_COMP) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (emit_load) begin
			dig_q <= {chain_q[6], chain_q[7], chain_q[4], chain_q[5],
			          chain_q[2], chain_q[3], chain_q[0], chain_q[1]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = dig_q;

endmodule

// ===== rtl/core/shm_checker.sv =====
// Port-level checker for the SHA-256 message hasher, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_message_hasher_core_macros.svh"
module shm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [255:0] m_axis_tdata
);

	`SHM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "digest dropped while stalled")
	`SHM_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "digest changed while stalled")
	`SHM_ASSERT_NEXT(a_end_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "end request not followed by padding")
	`SHM_ASSERT_NOW(a_out_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "digest appeared without hashing")

endmodule

bind sha256_message_hasher_core shm_checker u_shm_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the SHA-256 message hasher core, with its own hash predictor.
`timescale 1ns / 1ps
module tb;

	localparam logic [31:0] SHA_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_H0 [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int LEN_OFFSET = 56;
	localparam int BLOCK_BYTES = 64;

	typedef struct packed {
		logic [63:0] part_3;
		logic [63:0] part_2;
		logic [63:0] part_1;
		logic [63:0] part_0;
	} digest_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tuser = 1'b0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [255:0] m_axis_tdata;

	logic [31:0] hash_state [0:7];
	logic [7:0]  msg_block [0:63];
	int          block_len;
	logic [63:0] msg_bit_len;
	digest_t     pending_digests [$];

	int mismatch_count = 0;
	int src_idle_pct = 9;
	int sink_stall_pct = 82;

	sha256_message_hasher_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = SHA_H0[i];
		for (int i = 0; i < BLOCK_BYTES; i++)
			msg_block[i] = 8'h00;
		block_len = 0;
		msg_bit_len = 64'd0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] s0, s1, ch, maj, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			s1 = rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			s0 = rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + s1 + ch + SHA_K[i] + w[i];
			t2 = s0 + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endfunction

	function automatic void absorb_request(input logic [7:0] data, input logic present,
			input logic last);
		digest_t d;
		if (present) begin
			msg_block[block_len] = data;
			block_len = block_len + 1;
			msg_bit_len = msg_bit_len + 64'd8;
			if (block_len == BLOCK_BYTES) begin
				sha_compress();
				block_len = 0;
			end
		end
		if (!last)
			return;
		msg_block[block_len] = PAD_MARK;
		block_len = block_len + 1;
		if (block_len > LEN_OFFSET) begin
			while (block_len < BLOCK_BYTES) begin
				msg_block[block_len] = 8'h00;
				block_len = block_len + 1;
			end
			sha_compress();
			block_len = 0;
		end
		while (block_len < LEN_OFFSET) begin
			msg_block[block_len] = 8'h00;
			block_len = block_len + 1;
		end
		for (int i = 0; i < 8; i++)
			msg_block[LEN_OFFSET + i] = msg_bit_len[63 - 8*i -: 8];
		sha_compress();
		d.part_0 = {hash_state[0], hash_state[1]};
		d.part_1 = {hash_state[2], hash_state[3]};
		d.part_2 = {hash_state[4], hash_state[5]};
		d.part_3 = {hash_state[6], hash_state[7]};
		pending_digests.push_back(d);
		restart_hash();
	endfunction

	task automatic send_request(input logic [7:0] data, input logic present, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= present;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		absorb_request(data, present, last);
	endtask

	task automatic drain_digests();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_digests.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic test_directed_messages();
		// empty message, single bytes at both extremes
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'h5a, 1'b0, 1'b1);
		// ignored requests alone and inside a message
		send_request(8'ha5, 1'b0, 1'b0);
		send_request(8'hff, 1'b0, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h3c, 1'b0, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h7f, 1'b1, 1'b0);
		send_request(8'h01, 1'b1, 1'b0);
		send_request(8'hfe, 1'b0, 1'b1);
		drain_digests();
	endtask

	task automatic test_random_messages();
		int sent, msgs, len, body, pick;
		logic end_has_byte;
		sent = 0;
		msgs = 0;
		while (sent < 170 || msgs < 12) begin
			pick = $urandom_range(99);
			if (pick < 60)
				len = $urandom_range(0, 8);
			else if (pick < 90)
				len = 64 * $urandom_range(0, 1) + $urandom_range(55, 65);
			else
				len = $urandom_range(0, 130);
			end_has_byte = (len > 0) && ($urandom_range(1) == 1);
			body = end_has_byte ? len - 1 : len;
			for (int i = 0; i < body; i++) begin
				if ($urandom_range(99) < 5)
					send_request(8'($urandom_range(255)), 1'b0, 1'b0);
				send_request(8'($urandom_range(255)), 1'b1, 1'b0);
				sent++;
			end
			send_request(8'($urandom_range(255)), end_has_byte, 1'b1);
			sent++;
			msgs++;
		end
		drain_digests();
	endtask

	function automatic void compare_part(input int idx, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: digest_part_%0d expected %h actual %h", $time, idx, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		digest_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_digests.size() == 0) begin
					$display("%0t: unexpected digest, expected none actual %h", $time, got);
					mismatch_count++;
				end else begin
					want = pending_digests.pop_front();
					compare_part(0, want.part_0, got.part_0);
					compare_part(1, want.part_1, got.part_1);
					compare_part(2, want.part_2, got.part_2);
					compare_part(3, want.part_3, got.part_3);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		#5000000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		restart_hash();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_messages();
		test_random_messages();
		src_idle_pct = 82;
		sink_stall_pct = 9;
		test_random_messages();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_random_messages();
		if (pending_digests.size() != 0) begin
			$display("%0t: %0d digests expected, none arrived", $time, pending_digests.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/shm_pkg.sv
rtl/core/shm_round.sv
rtl/core/sha256_message_hasher_core.sv
rtl/core/shm_checker.sv
tb/tb.sv
